[rtl/iflf_pkg.sv]
// Shared types and constants for the look-ahead IIR/FIR filter.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none
package iflf_pkg;
  localparam int MaxTaps = 16;
  localparam int HistLen = 2 * MaxTaps;
  localparam int TapW = $clog2(MaxTaps);
  localparam int HistW = $clog2(HistLen);
  localparam int CntW = $clog2(MaxTaps + 1);

  localparam logic [1:0] FuncSample = 2'd0;
  localparam logic [1:0] FuncFwd = 2'd1;
  localparam logic [1:0] FuncFbk = 2'd2;
  localparam logic [1:0] FuncLah = 2'd3;

  localparam logic [1:0] ModeIir = 2'd0;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegFwd = 3'd1;
  localparam logic [2:0] RegFbk = 3'd2;
  localparam logic [2:0] RegLah = 3'd3;
  localparam logic [2:0] RegGain = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_DECIDE, ST_FWD, ST_FBK, ST_LAH, ST_ROUND, ST_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       take_item;  // capture input item
    logic       scale;      // shift history (clear it on first sample), store scaled sample
    logic       acc_clr;
    logic       mac_fwd;
    logic       mac_fbk;
    logic       mac_lah;
    logic [TapW-1:0] k;
    logic       finish;     // round and saturate into the output register
    logic       push_out;   // update output history
    logic       emit;       // output register becomes valid
    logic       last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic            is_sample;
    logic            first;
    logic            last;
    logic            out_busy;
  } sts_t;

  function automatic logic [CntW-1:0] clamp_taps(input logic [4:0] n);
    if (n == 5'd0) return CntW'(1);
    if (32'(n) > MaxTaps) return CntW'(MaxTaps);
    return CntW'(n);
  endfunction
endpackage
`default_nettype wire

[rtl/iir_fir_filter_with_lookahead.sv]
// Top level of the look-ahead IIR/FIR filter: APB registers, controller, datapath.
// Depends on iflf_pkg, iflf_ctrl and iflf_datapath.
//
// Channel   Direction  Payload
// s_axis    in         tdata {first, value, coef_index}, tuser func, tlast last
// m_axis    out        tdata filtered, tlast last_output, tuser clipped
// apb       in/out     filter_mode, forward/feedback/lookahead_taps, inverse_gain
//
// A coefficient write is captured and then written to its store. A sample is captured
// and scaled into the history; then, for each output it releases, the single shared
// multiply-accumulate walks the forward, feedback and look-ahead taps in use, followed
// by rounding and hand-over. Reset clears all coefficients, history and counters.
// A stalled output register holds the sequencer until the result is taken.
`default_nettype none
module iir_fir_filter_with_lookahead import iflf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata bits: [3:0] coef_index, [27:4] value, [28] first_sample, [31:29] 0
  input  wire logic [31:0] s_axis_tdata,
  // tuser bits: [1:0] func
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,   // last_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata bits: [23:0] filtered
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // last_output
  output logic             m_axis_tuser,   // clipped
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [1:0] mode_q;
  logic [4:0] fwd_q, fbk_q, lah_q;
  logic [23:0] gain_q;
  logic [CntW-1:0] nf, nb, nl, q;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];

  // Register writes land on the access phase of an APB request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      fwd_q <= 5'd1;
      fbk_q <= 5'd1;
      lah_q <= 5'd1;
      gain_q <= 24'd65536;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegMode: mode_q <= pwdata[1:0];
        RegFwd:  fwd_q <= pwdata[4:0];
        RegFbk:  fbk_q <= pwdata[4:0];
        RegLah:  lah_q <= pwdata[4:0];
        RegGain: gain_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegMode: prdata = {30'd0, mode_q};
      RegFwd:  prdata = {27'd0, fwd_q};
      RegFbk:  prdata = {27'd0, fbk_q};
      RegLah:  prdata = {27'd0, lah_q};
      RegGain: prdata = {8'd0, gain_q};
      default: prdata = '0;
    endcase
  end

  // Tap counts are clamped to one through the maximum before use.
  assign nf = clamp_taps(fwd_q);
  assign nb = clamp_taps(fbk_q);
  assign nl = clamp_taps(lah_q);

  iflf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .mode_i(mode_q),
    .nf_i(nf), .nb_i(nb), .nl_i(nl),
    .sts_i(sts), .cmd_o(cmd), .q_o(q)
  );

  iflf_datapath u_dp (
    .clk_i, .rst_ni,
    .func_i(s_axis_tuser),
    .coef_index_i(s_axis_tdata[3:0]),
    .value_i(s_axis_tdata[27:4]),
    .first_i(s_axis_tdata[28]),
    .last_i(s_axis_tlast),
    .gain_i(gain_q),
    .nf_i(nf), .nb_i(nb), .q_i(q),
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .filtered_o(m_axis_tdata),
    .last_output_o(m_axis_tlast),
    .clipped_o(m_axis_tuser)
  );
endmodule
`default_nettype wire

[rtl/iflf_ctrl.sv]
// Sequencer for the filter: walks taps of each pending output.
// Depends on iflf_pkg.
`default_nettype none
module iflf_ctrl import iflf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [CntW-1:0] nf_i,
  input  wire logic [CntW-1:0] nb_i,
  input  wire logic [CntW-1:0] nl_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o,
  output logic [CntW-1:0] q_o
);
  state_e state_q, state_d;
  logic [CntW-1:0] pend_q, pend_d;
  logic [TapW:0] k_q, k_d;
  logic [CntW-1:0] delay;
  logic use_fwd, use_lah;

  assign delay = mode_i[1] ? nl_i - CntW'(1) : '0;
  assign use_fwd = (mode_i == ModeIir) || mode_i[0];
  assign use_lah = mode_i[1] && (nl_i > CntW'(1));
  assign q_o = pend_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      k_q <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pend_d = pend_q;
    k_d = k_q;
    cmd_o = '0;
    cmd_o.k = k_q[TapW-1:0];
    cmd_o.last = sts_i.last && (pend_q == CntW'(1));
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!sts_i.is_sample) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scale = 1'b1;
          if (sts_i.first) pend_d = CntW'(1);
          else if (32'(pend_q) < MaxTaps) pend_d = pend_q + CntW'(1);
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.acc_clr = 1'b1;
        k_d = '0;
        if ((sts_i.last && pend_q != '0) || (!sts_i.last && pend_q > delay)) begin
          if (use_fwd) state_d = ST_FWD;
          else if (use_lah) begin
            state_d = ST_LAH;
            k_d = (TapW+1)'(1);
          end else state_d = ST_ROUND;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FWD: begin
        cmd_o.mac_fwd = 1'b1;
        k_d = k_q + 1'b1;
        if (CntW'(k_q) + CntW'(1) >= nf_i) begin
          k_d = '0;
          if (mode_i == ModeIir) begin
            // A feedback length of one uses no feedback taps.
            if (nb_i > CntW'(1)) state_d = ST_FBK;
            else state_d = ST_ROUND;
          end else if (use_lah) begin
            state_d = ST_LAH;
            k_d = (TapW+1)'(1);
          end else state_d = ST_ROUND;
        end
      end
      ST_FBK: begin
        cmd_o.mac_fbk = 1'b1;
        k_d = k_q + 1'b1;
        if (CntW'(k_q) + CntW'(2) >= nb_i) state_d = ST_ROUND;
      end
      ST_LAH: begin
        cmd_o.mac_lah = 1'b1;
        k_d = k_q + 1'b1;
        if (CntW'(k_q) + CntW'(1) >= nl_i) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        // The output register is only reloaded once its previous result has left.
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.push_out = (mode_i == ModeIir);
          pend_d = pend_q - CntW'(1);
          state_d = ST_DECIDE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> pend_q != '0) else $error("emit with nothing pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= MaxTaps) else $error("pending count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

[rtl/iflf_datapath.sv]
// Datapath: coefficient and history stores, one shared MAC, output register.
// Depends on iflf_pkg.
`default_nettype none
module iflf_datapath import iflf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  func_i,
  input  wire logic [3:0]  coef_index_i,
  input  wire logic signed [23:0] value_i,
  input  wire logic        first_i,
  input  wire logic        last_i,
  input  wire logic [23:0] gain_i,
  input  wire logic [CntW-1:0] nf_i,
  input  wire logic [CntW-1:0] nb_i,
  input  wire logic [CntW-1:0] q_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [23:0] filtered_o,
  output logic             last_output_o,
  output logic             clipped_o
);
  logic signed [23:0] fwd_q [MaxTaps];
  logic signed [23:0] fbk_q [MaxTaps];
  logic signed [23:0] lah_q [MaxTaps];
  logic signed [23:0] sh_q [HistLen];
  logic signed [23:0] oh_q [MaxTaps];
  logic [1:0] func_q;
  logic [3:0] idx_q;
  logic signed [23:0] val_q;
  logic first_q, last_q;
  logic signed [55:0] acc_q;
  logic out_valid_q;
  logic signed [23:0] y_q;
  logic last_out_q, clip_q;
  logic coef_we, wr_pend_q;

  logic signed [48:0] sprod;
  logic signed [48:0] srnd;
  logic signed [23:0] ssat;
  logic signed [23:0] ca, xb;
  logic xvalid;
  logic [HistW:0] hidx;
  logic [CntW:0] oidx;
  logic signed [47:0] prod;
  logic signed [56:0] arnd;
  logic signed [36:0] ashift;
  logic signed [23:0] ysat;
  logic yclip;

  assign sprod = 49'(val_q) * $signed({1'b0, gain_i});
  assign srnd = (sprod + 49'sd32768) >>> 16;
  assign ssat = (srnd > 49'sd8388607) ? 24'sh7FFFFF :
                (srnd < -49'sd8388608) ? 24'sh800000 : srnd[23:0];

  always_comb begin
    ca = '0;
    xb = '0;
    xvalid = 1'b0;
    hidx = '0;
    oidx = '0;
    if (cmd_i.mac_fwd) begin
      hidx = (HistW+1)'(q_i) + (HistW+1)'(nf_i) - (HistW+1)'(1) - (HistW+1)'(cmd_i.k);
      ca = fwd_q[cmd_i.k];
      xvalid = hidx < (HistW+1)'(HistLen);
      xb = sh_q[hidx[HistW-1:0]];
    end else if (cmd_i.mac_fbk) begin
      oidx = (CntW+1)'(nb_i) - (CntW+1)'(2) - (CntW+1)'(cmd_i.k);
      ca = fbk_q[cmd_i.k];
      xvalid = 1'b1;
      xb = oh_q[oidx[TapW-1:0]];
    end else if (cmd_i.mac_lah) begin
      hidx = (HistW+1)'(q_i) - (HistW+1)'(cmd_i.k);
      ca = lah_q[cmd_i.k];
      xvalid = (CntW'(cmd_i.k) <= q_i);
      xb = sh_q[hidx[HistW-1:0]];
    end
  end

  assign prod = xvalid ? 48'(ca * xb) : '0;
  assign arnd = (57'(acc_q) + 57'sd524288) >>> 20;
  assign ashift = arnd[36:0];
  assign yclip = (ashift > 37'sd8388607) || (ashift < -37'sd8388608);
  assign ysat = (ashift > 37'sd8388607) ? 24'sh7FFFFF :
                (ashift < -37'sd8388608) ? 24'sh800000 : ashift[23:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      func_q <= func_i;
      idx_q <= coef_index_i;
      val_q <= value_i;
      first_q <= first_i;
      last_q <= last_i;
    end
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.mac_fwd || cmd_i.mac_fbk || cmd_i.mac_lah) acc_q <= acc_q + 56'(prod);
    if (cmd_i.finish) begin
      y_q <= ysat;
      clip_q <= yclip;
      last_out_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTaps; i++) begin
        fwd_q[i] <= '0;
        fbk_q[i] <= '0;
        lah_q[i] <= '0;
        oh_q[i] <= '0;
      end
      for (int i = 0; i < HistLen; i++) sh_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scale) begin
        sh_q[0] <= ssat;
        for (int i = 1; i < HistLen; i++) sh_q[i] <= first_q ? '0 : sh_q[i-1];
        if (first_q) for (int i = 0; i < MaxTaps; i++) oh_q[i] <= '0;
      end
      if (cmd_i.push_out) begin
        oh_q[0] <= y_q;
        for (int i = 1; i < MaxTaps; i++) oh_q[i] <= oh_q[i-1];
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (coef_we) begin
        case (func_q)
          FuncFwd: fwd_q[idx_q[TapW-1:0]] <= val_q;
          FuncFbk: fbk_q[idx_q[TapW-1:0]] <= val_q;
          FuncLah: lah_q[idx_q[TapW-1:0]] <= val_q;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wr_pend_q <= 1'b0;
    else wr_pend_q <= cmd_i.take_item;
  end
  assign coef_we = wr_pend_q && (func_q != FuncSample) && (32'(idx_q) < MaxTaps);

  assign sts_o.is_sample = (func_q == FuncSample);
  assign sts_o.first = first_q;
  assign sts_o.last = last_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign filtered_o = y_q;
  assign last_output_o = last_out_q;
  assign clipped_o = clip_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i)) else $error("output overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(y_q)) else $error("result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_clr |-> !(cmd_i.mac_fwd || cmd_i.mac_lah)) else $error("clear with mac");
endmodule
`default_nettype wire
